[rtl/ppc_pkg.sv]
// Shared constants, stage map, pipeline record and saturation helper for
// particle_pair_collision. No dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int WB        = WORD_BITS;
  localparam int FB        = FRAC_BITS;

  // width used for the final sums ahead of saturation
  localparam int SAT_W = WB + 8;

  // restitution 0.8 rounded to FB fraction bits, plus one
  localparam int REST_Q = ((8 << FB) + 5) / 10;
  localparam logic [FB:0] E_COEF = (FB + 1)'((1 << FB) + REST_Q);

  // contact status codes
  localparam logic [1:0] CS_NONE       = 2'd0;
  localparam logic [1:0] CS_IMPULSE    = 2'd1;
  localparam logic [1:0] CS_SEPARATE   = 2'd2;
  localparam logic [1:0] CS_COINCIDENT = 2'd3;

  // stage map
  localparam int S_IN  = 0;
  localparam int S_SQ  = 1;
  localparam int S_CMP = 2;
  localparam int S_RT0 = 3;             // WB square-root digit stages
  localparam int S_PEN = S_RT0 + WB;
  localparam int S_DV0 = S_PEN + 1;     // WB long-division stages
  localparam int S_P1  = S_DV0 + WB;
  localparam int S_P2  = S_P1 + 1;
  localparam int S_P3  = S_P2 + 1;
  localparam int S_P4  = S_P3 + 1;
  localparam int S_P5  = S_P4 + 1;
  localparam int NSTG  = S_P5 + 1;
  localparam int LAST  = NSTG - 1;

  typedef struct packed {
    logic [WB-1:0]   ax, ay, avx, avy, bx, by, bvx, bvy;
    logic [WB-1:0]   rs, tot;
    logic [WB-2:0]   ma, mb;
    logic            sx, sy;
    logic [WB-1:0]   udx, udy;
    logic [WB:0]     rvx, rvy;
    logic [2*WB-1:0] sq1, sq2, rs2, s;
    logic            hit, zero;
    logic [WB:0]     srem;
    logic [WB-1:0]   root;
    logic [WB-1:0]   warem, wbrem;
    logic [FB-1:0]   wa, wb;
    logic [WB-1:0]   pen;
    logic [2*WB-1:0] px, py;
    logic [WB-1:0]   mxrem, myrem, mxq, myq;
    logic [WB-1:0]   nxrem, nyrem;
    logic [FB:0]     nxq, nyq;
    logic [WB-1:0]   sax, say, sbx, sby;
    logic [WB+1:0]   tvx, tvy;
    logic [WB-1:0]   pax, pay, pbx, pby;
    logic [WB+3:0]   nvn;
    logic [1:0]      status;
    logic [WB+4:0]   j;
    logic [WB+5:0]   ixm, iym;
    logic [WB+5:0]   iax, iay, ibx, iby;
  } pp_t;

  typedef struct packed {
    logic [WB-1:0] pax, pay, avx, avy, pbx, pby, bvx, bvy;
    logic [1:0]    status;
  } ob_t;

  function automatic logic [WB-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({{(SAT_W-WB+1){1'b0}}, {(WB-1){1'b1}}});
    lo = $signed({{(SAT_W-WB+1){1'b1}}, {(WB-1){1'b0}}});
    if (v > hi) begin
      return {1'b0, {(WB-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(WB-1){1'b0}}};
    end
    return v[WB-1:0];
  endfunction

endpackage

[rtl/particle_pair_collision.sv]
// Two-circle collision check and response, fully pipelined.
// Depends on ppc_pkg (constants, stage map, pipeline record, saturation).
//
// Usage:
//   Input channel in_valid/in_ready carries one circle pair per transaction
//   (positions, velocities in signed Q16.16, radii and masses unsigned).
//   Output channel out_valid/out_ready returns the updated pair and
//   out_contact_status (0 none, 1 separated with impulse, 2 separated only,
//   3 coincident centres).
//   The pipeline runs the bit-per-stage square root (WORD_BITS stages), then the
//   bit-per-stage divider for the penetration vector and unit normal (WORD_BITS
//   stages); the rest is multiply/add stages, followed by the output register.
//   Throughput: one pair per cycle while the pipeline is not frozen by a stall.
//   Reset (rst_n low, synchronous) empties all stages and the output register.
//   Stall: the last pipeline stage doubles as a skid entry behind the output
//   register, so a pending result does not block input by itself; only when
//   both hold data and out_ready is low does the whole pipeline freeze.
//   in_ready depends combinationally on out_ready.
`timescale 1ns / 1ps

module particle_pair_collision
  import ppc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [WB-1:0] in_a_pos_x,
  input  logic signed [WB-1:0] in_a_pos_y,
  input  logic signed [WB-1:0] in_a_vel_x,
  input  logic signed [WB-1:0] in_a_vel_y,
  input  logic        [WB-2:0] in_a_radius,
  input  logic        [WB-2:0] in_a_mass,
  input  logic signed [WB-1:0] in_b_pos_x,
  input  logic signed [WB-1:0] in_b_pos_y,
  input  logic signed [WB-1:0] in_b_vel_x,
  input  logic signed [WB-1:0] in_b_vel_y,
  input  logic        [WB-2:0] in_b_radius,
  input  logic        [WB-2:0] in_b_mass,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [WB-1:0] out_new_a_pos_x,
  output logic signed [WB-1:0] out_new_a_pos_y,
  output logic signed [WB-1:0] out_new_a_vel_x,
  output logic signed [WB-1:0] out_new_a_vel_y,
  output logic signed [WB-1:0] out_new_b_pos_x,
  output logic signed [WB-1:0] out_new_b_pos_y,
  output logic signed [WB-1:0] out_new_b_vel_x,
  output logic signed [WB-1:0] out_new_b_vel_y,
  output logic        [1:0]    out_contact_status
);

  pp_t             pipe_r   [NSTG];
  pp_t             pipe_nxt [NSTG];
  logic [NSTG-1:0] v_r;
  logic            ov_r;
  ob_t             ob_r;
  ob_t             ob_nxt;
  logic            out_free;
  logic            adv;

  assign out_free = !ov_r || out_ready;
  assign adv      = !v_r[LAST] || out_free;
  assign in_ready = adv;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    if (k == S_IN) begin : g_in
      always_comb begin
        logic signed [WB:0] dx, dy;
        logic [WB-2:0]      ma, mb;
        pipe_nxt[k] = '0;
        pipe_nxt[k].ax  = in_a_pos_x;
        pipe_nxt[k].ay  = in_a_pos_y;
        pipe_nxt[k].avx = in_a_vel_x;
        pipe_nxt[k].avy = in_a_vel_y;
        pipe_nxt[k].bx  = in_b_pos_x;
        pipe_nxt[k].by  = in_b_pos_y;
        pipe_nxt[k].bvx = in_b_vel_x;
        pipe_nxt[k].bvy = in_b_vel_y;
        dx = $signed({in_a_pos_x[WB-1], in_a_pos_x}) - $signed({in_b_pos_x[WB-1], in_b_pos_x});
        dy = $signed({in_a_pos_y[WB-1], in_a_pos_y}) - $signed({in_b_pos_y[WB-1], in_b_pos_y});
        pipe_nxt[k].sx  = dx[WB];
        pipe_nxt[k].sy  = dy[WB];
        pipe_nxt[k].udx = dx[WB] ? WB'(-dx) : WB'(dx);
        pipe_nxt[k].udy = dy[WB] ? WB'(-dy) : WB'(dy);
        pipe_nxt[k].rvx = $signed({in_a_vel_x[WB-1], in_a_vel_x})
                        - $signed({in_b_vel_x[WB-1], in_b_vel_x});
        pipe_nxt[k].rvy = $signed({in_a_vel_y[WB-1], in_a_vel_y})
                        - $signed({in_b_vel_y[WB-1], in_b_vel_y});
        // zero mass acts as one LSB
        ma = (in_a_mass == '0) ? (WB-1)'(1) : in_a_mass;
        mb = (in_b_mass == '0) ? (WB-1)'(1) : in_b_mass;
        pipe_nxt[k].ma  = ma;
        pipe_nxt[k].mb  = mb;
        pipe_nxt[k].tot = {1'b0, ma} + {1'b0, mb};
        pipe_nxt[k].rs  = {1'b0, in_a_radius} + {1'b0, in_b_radius};
      end
    end else if (k == S_SQ) begin : g_sq
      always_comb begin
        pipe_nxt[k]     = pipe_r[k-1];
        pipe_nxt[k].sq1 = pipe_r[k-1].udx * pipe_r[k-1].udx;
        pipe_nxt[k].sq2 = pipe_r[k-1].udy * pipe_r[k-1].udy;
        pipe_nxt[k].rs2 = pipe_r[k-1].rs * pipe_r[k-1].rs;
      end
    end else if (k == S_CMP) begin : g_cmp
      always_comb begin
        logic [2*WB:0] sum;
        pipe_nxt[k] = pipe_r[k-1];
        sum = {1'b0, pipe_r[k-1].sq1} + {1'b0, pipe_r[k-1].sq2};
        pipe_nxt[k].s     = sum[2*WB-1:0];
        pipe_nxt[k].hit   = !sum[2*WB] && (sum[2*WB-1:0] < pipe_r[k-1].rs2);
        pipe_nxt[k].zero  = (sum[2*WB-1:0] == '0);
        pipe_nxt[k].srem  = '0;
        pipe_nxt[k].root  = '0;
        pipe_nxt[k].warem = {1'b0, pipe_r[k-1].mb};
        pipe_nxt[k].wbrem = {1'b0, pipe_r[k-1].ma};
        pipe_nxt[k].wa    = '0;
        pipe_nxt[k].wb    = '0;
      end
    end else if (k >= S_RT0 && k < S_PEN) begin : g_root
      localparam int I = k - S_RT0;
      localparam int P = WB - 1 - I;
      always_comb begin
        logic [WB+1:0] rem_n, trial;
        logic [WB:0]   wr_a, wr_b;
        pipe_nxt[k] = pipe_r[k-1];
        // one result bit per stage, two radicand bits in
        rem_n = {pipe_r[k-1].srem[WB-1:0], pipe_r[k-1].s[2*P+1 -: 2]};
        trial = {pipe_r[k-1].root, 2'b01};
        if (rem_n >= trial) begin
          pipe_nxt[k].srem = (WB+1)'(rem_n - trial);
          pipe_nxt[k].root = {pipe_r[k-1].root[WB-2:0], 1'b1};
        end else begin
          pipe_nxt[k].srem = (WB+1)'(rem_n);
          pipe_nxt[k].root = {pipe_r[k-1].root[WB-2:0], 1'b0};
        end
        // mass shares run alongside in the first FB stages
        wr_a = {pipe_r[k-1].warem, 1'b0};
        wr_b = {pipe_r[k-1].wbrem, 1'b0};
        if (I < FB) begin
          if (wr_a >= {1'b0, pipe_r[k-1].tot}) begin
            pipe_nxt[k].warem = WB'(wr_a - {1'b0, pipe_r[k-1].tot});
            pipe_nxt[k].wa    = {pipe_r[k-1].wa[FB-2:0], 1'b1};
          end else begin
            pipe_nxt[k].warem = WB'(wr_a);
            pipe_nxt[k].wa    = {pipe_r[k-1].wa[FB-2:0], 1'b0};
          end
          if (wr_b >= {1'b0, pipe_r[k-1].tot}) begin
            pipe_nxt[k].wbrem = WB'(wr_b - {1'b0, pipe_r[k-1].tot});
            pipe_nxt[k].wb    = {pipe_r[k-1].wb[FB-2:0], 1'b1};
          end else begin
            pipe_nxt[k].wbrem = WB'(wr_b);
            pipe_nxt[k].wb    = {pipe_r[k-1].wb[FB-2:0], 1'b0};
          end
        end
      end
    end else if (k == S_PEN) begin : g_pen
      always_comb begin
        logic [WB-1:0] pen;
        pipe_nxt[k] = pipe_r[k-1];
        pen = pipe_r[k-1].rs - pipe_r[k-1].root;
        pipe_nxt[k].pen   = pen;
        pipe_nxt[k].px    = pipe_r[k-1].udx * pen;
        pipe_nxt[k].py    = pipe_r[k-1].udy * pen;
        pipe_nxt[k].mxrem = '0;
        pipe_nxt[k].myrem = '0;
        pipe_nxt[k].mxq   = '0;
        pipe_nxt[k].myq   = '0;
        pipe_nxt[k].nxrem = {1'b0, pipe_r[k-1].udx[WB-1:1]};
        pipe_nxt[k].nyrem = {1'b0, pipe_r[k-1].udy[WB-1:1]};
        pipe_nxt[k].nxq   = '0;
        pipe_nxt[k].nyq   = '0;
      end
    end else if (k >= S_DV0 && k < S_P1) begin : g_div
      localparam int I = k - S_DV0;
      localparam int B = WB - 1 - I;
      always_comb begin
        logic [WB-1:0] rc_x, rc_y, d;
        logic [WB:0]   rn_x, rn_y, nn_x, nn_y;
        pipe_nxt[k] = pipe_r[k-1];
        d = pipe_r[k-1].root;
        // quotient below 2^WB, so the upper half is already below d
        rc_x = (I == 0) ? pipe_r[k-1].px[2*WB-1:WB] : pipe_r[k-1].mxrem;
        rc_y = (I == 0) ? pipe_r[k-1].py[2*WB-1:WB] : pipe_r[k-1].myrem;
        rn_x = {rc_x, pipe_r[k-1].px[B]};
        rn_y = {rc_y, pipe_r[k-1].py[B]};
        if (rn_x >= {1'b0, d}) begin
          pipe_nxt[k].mxrem = WB'(rn_x - {1'b0, d});
          pipe_nxt[k].mxq   = {pipe_r[k-1].mxq[WB-2:0], 1'b1};
        end else begin
          pipe_nxt[k].mxrem = WB'(rn_x);
          pipe_nxt[k].mxq   = {pipe_r[k-1].mxq[WB-2:0], 1'b0};
        end
        if (rn_y >= {1'b0, d}) begin
          pipe_nxt[k].myrem = WB'(rn_y - {1'b0, d});
          pipe_nxt[k].myq   = {pipe_r[k-1].myq[WB-2:0], 1'b1};
        end else begin
          pipe_nxt[k].myrem = WB'(rn_y);
          pipe_nxt[k].myq   = {pipe_r[k-1].myq[WB-2:0], 1'b0};
        end
        // unit normal: (|delta| << FB) / d, FB+1 quotient bits
        nn_x = {pipe_r[k-1].nxrem, (I == 0) ? pipe_r[k-1].udx[0] : 1'b0};
        nn_y = {pipe_r[k-1].nyrem, (I == 0) ? pipe_r[k-1].udy[0] : 1'b0};
        if (I <= FB) begin
          if (nn_x >= {1'b0, d}) begin
            pipe_nxt[k].nxrem = WB'(nn_x - {1'b0, d});
            pipe_nxt[k].nxq   = {pipe_r[k-1].nxq[FB-1:0], 1'b1};
          end else begin
            pipe_nxt[k].nxrem = WB'(nn_x);
            pipe_nxt[k].nxq   = {pipe_r[k-1].nxq[FB-1:0], 1'b0};
          end
          if (nn_y >= {1'b0, d}) begin
            pipe_nxt[k].nyrem = WB'(nn_y - {1'b0, d});
            pipe_nxt[k].nyq   = {pipe_r[k-1].nyq[FB-1:0], 1'b1};
          end else begin
            pipe_nxt[k].nyrem = WB'(nn_y);
            pipe_nxt[k].nyq   = {pipe_r[k-1].nyq[FB-1:0], 1'b0};
          end
        end
      end
    end else if (k == S_P1) begin : g_p1
      always_comb begin
        logic [WB+FB-1:0] p_ax, p_ay, p_bx, p_by;
        logic [WB:0]      urx, ury;
        logic [WB+FB+1:0] p_tx, p_ty;
        pipe_nxt[k] = pipe_r[k-1];
        p_ax = pipe_r[k-1].mxq * pipe_r[k-1].wa;
        p_ay = pipe_r[k-1].myq * pipe_r[k-1].wa;
        p_bx = pipe_r[k-1].mxq * pipe_r[k-1].wb;
        p_by = pipe_r[k-1].myq * pipe_r[k-1].wb;
        pipe_nxt[k].sax = p_ax[WB+FB-1:FB];
        pipe_nxt[k].say = p_ay[WB+FB-1:FB];
        pipe_nxt[k].sbx = p_bx[WB+FB-1:FB];
        pipe_nxt[k].sby = p_by[WB+FB-1:FB];
        urx = pipe_r[k-1].rvx[WB] ? -pipe_r[k-1].rvx : pipe_r[k-1].rvx;
        ury = pipe_r[k-1].rvy[WB] ? -pipe_r[k-1].rvy : pipe_r[k-1].rvy;
        p_tx = urx * pipe_r[k-1].nxq;
        p_ty = ury * pipe_r[k-1].nyq;
        pipe_nxt[k].tvx = p_tx[WB+FB+1:FB];
        pipe_nxt[k].tvy = p_ty[WB+FB+1:FB];
      end
    end else if (k == S_P2) begin : g_p2
      always_comb begin
        logic signed [SAT_W-1:0] dax, day, dbx, dby;
        logic signed [WB+3:0]    vx, vy, vn;
        logic                    approach, moved;
        pp_t                     p;
        p = pipe_r[k-1];
        pipe_nxt[k] = p;
        dax = p.sx ? -$signed({8'd0, p.sax}) : $signed({8'd0, p.sax});
        day = p.sy ? -$signed({8'd0, p.say}) : $signed({8'd0, p.say});
        dbx = p.sx ? -$signed({8'd0, p.sbx}) : $signed({8'd0, p.sbx});
        dby = p.sy ? -$signed({8'd0, p.sby}) : $signed({8'd0, p.sby});
        moved = p.hit && !p.zero;
        pipe_nxt[k].pax = moved ? sat_word(SAT_W'($signed(p.ax)) + dax) : p.ax;
        pipe_nxt[k].pay = moved ? sat_word(SAT_W'($signed(p.ay)) + day) : p.ay;
        pipe_nxt[k].pbx = moved ? sat_word(SAT_W'($signed(p.bx)) - dbx) : p.bx;
        pipe_nxt[k].pby = moved ? sat_word(SAT_W'($signed(p.by)) - dby) : p.by;
        vx = (p.rvx[WB] ^ p.sx) ? -$signed({2'b0, p.tvx}) : $signed({2'b0, p.tvx});
        vy = (p.rvy[WB] ^ p.sy) ? -$signed({2'b0, p.tvy}) : $signed({2'b0, p.tvy});
        vn = vx + vy;
        approach = vn[WB+3] || (vn == '0);
        pipe_nxt[k].nvn = approach ? (WB+4)'(-vn) : '0;
        if (!p.hit) begin
          pipe_nxt[k].status = CS_NONE;
        end else if (p.zero) begin
          pipe_nxt[k].status = CS_COINCIDENT;
        end else if (approach) begin
          pipe_nxt[k].status = CS_IMPULSE;
        end else begin
          pipe_nxt[k].status = CS_SEPARATE;
        end
      end
    end else if (k == S_P3) begin : g_p3
      always_comb begin
        logic [WB+FB+4:0] pj;
        pipe_nxt[k] = pipe_r[k-1];
        pj = pipe_r[k-1].nvn * E_COEF;
        pipe_nxt[k].j = pj[WB+FB+4:FB];
      end
    end else if (k == S_P4) begin : g_p4
      always_comb begin
        logic [WB+FB+5:0] pxm, pym;
        pipe_nxt[k] = pipe_r[k-1];
        pxm = pipe_r[k-1].nxq * pipe_r[k-1].j;
        pym = pipe_r[k-1].nyq * pipe_r[k-1].j;
        pipe_nxt[k].ixm = pxm[WB+FB+5:FB];
        pipe_nxt[k].iym = pym[WB+FB+5:FB];
      end
    end else begin : g_p5
      always_comb begin
        logic [WB+FB+5:0] q_ax, q_ay, q_bx, q_by;
        pipe_nxt[k] = pipe_r[k-1];
        q_ax = pipe_r[k-1].ixm * pipe_r[k-1].wa;
        q_ay = pipe_r[k-1].iym * pipe_r[k-1].wa;
        q_bx = pipe_r[k-1].ixm * pipe_r[k-1].wb;
        q_by = pipe_r[k-1].iym * pipe_r[k-1].wb;
        pipe_nxt[k].iax = q_ax[WB+FB+5:FB];
        pipe_nxt[k].iay = q_ay[WB+FB+5:FB];
        pipe_nxt[k].ibx = q_bx[WB+FB+5:FB];
        pipe_nxt[k].iby = q_by[WB+FB+5:FB];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // velocity update and output register
  always_comb begin
    logic signed [SAT_W-1:0] dax, day, dbx, dby;
    logic                    imp;
    pp_t                     p;
    p = pipe_r[LAST];
    dax = p.sx ? -$signed({2'b0, p.iax}) : $signed({2'b0, p.iax});
    day = p.sy ? -$signed({2'b0, p.iay}) : $signed({2'b0, p.iay});
    dbx = p.sx ? -$signed({2'b0, p.ibx}) : $signed({2'b0, p.ibx});
    dby = p.sy ? -$signed({2'b0, p.iby}) : $signed({2'b0, p.iby});
    imp = (p.status == CS_IMPULSE);
    ob_nxt.pax    = p.pax;
    ob_nxt.pay    = p.pay;
    ob_nxt.pbx    = p.pbx;
    ob_nxt.pby    = p.pby;
    ob_nxt.avx    = imp ? sat_word(SAT_W'($signed(p.avx)) + dax) : p.avx;
    ob_nxt.avy    = imp ? sat_word(SAT_W'($signed(p.avy)) + day) : p.avy;
    ob_nxt.bvx    = imp ? sat_word(SAT_W'($signed(p.bvx)) - dbx) : p.bvx;
    ob_nxt.bvy    = imp ? sat_word(SAT_W'($signed(p.bvy)) - dby) : p.bvy;
    ob_nxt.status = p.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      if (adv) begin
        v_r <= {v_r[NSTG-2:0], in_valid};
      end
      if (out_free) begin
        ov_r <= v_r[LAST];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v_r[LAST]) begin
      ob_r <= ob_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_new_a_pos_x    = ob_r.pax;
  assign out_new_a_pos_y    = ob_r.pay;
  assign out_new_a_vel_x    = ob_r.avx;
  assign out_new_a_vel_y    = ob_r.avy;
  assign out_new_b_pos_x    = ob_r.pbx;
  assign out_new_b_pos_y    = ob_r.pby;
  assign out_new_b_vel_x    = ob_r.bvx;
  assign out_new_b_vel_y    = ob_r.bvy;
  assign out_contact_status = ob_r.status;

endmodule
